FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DTL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DTL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DTL_ASSERT_IMP(label, ante, cons, msg)
`define DTL_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/dtl_pkg.sv
// ----------------------------------------------------------------------------
// Delta timer list package
// Field widths, operation codes and the layout of one timer table row.
// ----------------------------------------------------------------------------
package dtl_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_W         = 24;
    localparam int ID_W           = 4;
    localparam int OP_W           = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] prior_rem;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] period;
    } row_t;

endpackage

FILE: hdl/dtl_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Carries one add, remove or tick command per beat.
// ----------------------------------------------------------------------------
interface dtl_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dtl_pkg::OP_W-1:0]      operation;
    logic [dtl_pkg::ID_W-1:0]      timer_id;
    logic [dtl_pkg::TIME_W-1:0]    period_ms;
    logic                          reload_flag;
    logic [dtl_pkg::TIME_W-1:0]    elapsed_ms;

    modport source (output valid, operation, timer_id, period_ms, reload_flag, elapsed_ms,
                    input ready);
    modport sink   (input valid, operation, timer_id, period_ms, reload_flag, elapsed_ms,
                    output ready);
endinterface

FILE: hdl/dtl_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one expiry or acknowledge per beat.
// ----------------------------------------------------------------------------
interface dtl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          expired_valid;
    logic [dtl_pkg::ID_W-1:0]      expired_id;
    logic [dtl_pkg::TIME_W-1:0]    next_timeout_ms;
    logic                          status;
    logic                          last;

    modport source (output valid, expired_valid, expired_id, next_timeout_ms, status, last,
                    input ready);
    modport sink   (input valid, expired_valid, expired_id, next_timeout_ms, status, last,
                    output ready);
endinterface

FILE: hdl/dtl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/delta_timer_list_manager_top.sv
// ----------------------------------------------------------------------------
// Delta timer list manager
// Timer table in RAM; one scan pass per command, one sort pass per expiry.
// ----------------------------------------------------------------------------
// Add, remove and unused codes get a single response beat each.
// A tick with k expiries gives k beats, the last one flagged; with none it gives a single beat.
// Throughput is set by the single read port of the timer RAM, one slot per cycle.
// A command is taken whenever the sequencer is idle, even with a response pending.
// Reset clears the armed marks at once, so every slot starts disarmed without a sweep.
`include "assert_macros.svh"

module delta_timer_list_manager_top #(
    parameter int NUM_TIMERS = dtl_pkg::NUM_TIMERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dtl_cmd_if.sink       cmd,
    dtl_rsp_if.source     rsp
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int ROW_W = $bits(dtl_pkg::row_t);
    localparam int TW    = dtl_pkg::TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_SELECT,
        ST_PICK,
        ST_RESULT
    } state_t;

    state_t                      state_reg, state_next;
    logic [dtl_pkg::OP_W-1:0]    op_reg, op_next;
    logic [dtl_pkg::ID_W-1:0]    id_reg, id_next;
    logic [TW-1:0]               period_reg, period_next;
    logic                        reload_reg, reload_next;
    logic [TW-1:0]               elapsed_reg, elapsed_next;
    logic                        status_reg, status_next;
    logic [NUM_TIMERS-1:0]       armed_reg, armed_next;
    logic [NUM_TIMERS-1:0]       periodic_reg, periodic_next;
    logic [NUM_TIMERS-1:0]       exp_mask_reg, exp_mask_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        pv_reg, pv_next;
    logic [IDX_W-1:0]            pidx_reg, pidx_next;
    logic                        min_found_reg, min_found_next;
    logic [TW-1:0]               min_reg, min_next;
    logic                        best_found_reg, best_found_next;
    logic [TW-1:0]               best_rem_reg, best_rem_next;
    logic [IDX_W-1:0]            best_idx_reg, best_idx_next;

    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        rsp_exp_reg, rsp_exp_next;
    logic [dtl_pkg::ID_W-1:0]    rsp_id_reg, rsp_id_next;
    logic [TW-1:0]               rsp_time_reg, rsp_time_next;
    logic                        rsp_status_reg, rsp_status_next;
    logic                        rsp_last_reg, rsp_last_next;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    dtl_pkg::row_t               ram_wdata;
    logic                        ram_re;
    logic [IDX_W-1:0]            ram_raddr;
    dtl_pkg::row_t               ram_rdata;

    logic                        out_free;
    logic                        is_tick;
    logic                        id_ok;
    logic [31:0]                 id_ext;
    logic [IDX_W-1:0]            slot;
    logic                        rd_issue;
    logic                        pass_last;
    logic [TW-1:0]               next_time;
    logic [NUM_TIMERS-1:0]       pick_bit;
    logic [NUM_TIMERS-1:0]       mask_after;
    logic [31:0]                 best_ext;
    logic                        still_armed;
    logic [TW-1:0]               new_rem;

    dtl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_TIMERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.expired_valid   = rsp_exp_reg;
    assign rsp.expired_id      = rsp_id_reg;
    assign rsp.next_timeout_ms = rsp_time_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.last            = rsp_last_reg;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign is_tick   = (op_reg == dtl_pkg::OP_TICK);
    assign id_ext    = 32'(id_reg);
    assign id_ok     = (id_ext < 32'(NUM_TIMERS));
    assign slot      = id_ext[IDX_W-1:0];
    assign rd_issue  = (cnt_reg < CNT_W'(NUM_TIMERS));
    assign pass_last = pv_reg && (pidx_reg == IDX_W'(NUM_TIMERS - 1));
    assign next_time = min_found_reg ? min_reg : '0;
    assign best_ext  = 32'(best_idx_reg);

    always_comb
    begin
        pick_bit               = '0;
        pick_bit[best_idx_reg] = 1'b1;
        mask_after             = exp_mask_reg & ~pick_bit;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        reload_next     = reload_reg;
        elapsed_next    = elapsed_reg;
        status_next     = status_reg;
        armed_next      = armed_reg;
        periodic_next   = periodic_reg;
        exp_mask_next   = exp_mask_reg;
        cnt_next        = cnt_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        min_found_next  = min_found_reg;
        min_next        = min_reg;
        best_found_next = best_found_reg;
        best_rem_next   = best_rem_reg;
        best_idx_next   = best_idx_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_exp_next    = rsp_exp_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_time_next   = rsp_time_reg;
        rsp_status_next = rsp_status_reg;
        rsp_last_next   = rsp_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = pidx_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = cnt_reg[IDX_W-1:0];
        still_armed     = 1'b0;
        new_rem         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next      = cmd.operation;
                    id_next      = cmd.timer_id;
                    period_next  = cmd.period_ms;
                    reload_next  = cmd.reload_flag;
                    elapsed_next = cmd.elapsed_ms;
                    state_next   = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                status_next = 1'b0;
                case (op_reg)
                    dtl_pkg::OP_ADD:
                    begin
                        if (id_ok)
                        begin
                            ram_we              = 1'b1;
                            ram_waddr           = slot;
                            ram_wdata.prior_rem = '0;
                            ram_wdata.rem       = period_reg;
                            ram_wdata.period    = period_reg;
                            armed_next[slot]    = 1'b1;
                            periodic_next[slot] = reload_reg;
                        end
                    end
                    dtl_pkg::OP_REMOVE:
                    begin
                        if (id_ok && armed_reg[slot])
                        begin
                            armed_next[slot] = 1'b0;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                cnt_next       = '0;
                pv_next        = 1'b0;
                min_found_next = 1'b0;
                min_next       = '0;
                exp_mask_next  = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                pv_next = rd_issue;
                if (rd_issue)
                begin
                    ram_re    = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pv_reg)
                begin
                    still_armed = armed_reg[pidx_reg];
                    new_rem     = ram_rdata.rem;
                    if (is_tick && armed_reg[pidx_reg])
                    begin
                        if (ram_rdata.rem <= elapsed_reg)
                        begin
                            exp_mask_next[pidx_reg] = 1'b1;
                            if (periodic_reg[pidx_reg])
                            begin
                                new_rem = ram_rdata.period;
                            end
                            else
                            begin
                                still_armed          = 1'b0;
                                armed_next[pidx_reg] = 1'b0;
                                new_rem              = '0;
                            end
                        end
                        else
                        begin
                            new_rem = ram_rdata.rem - elapsed_reg;
                        end
                    end
                    if (is_tick)
                    begin
                        ram_we              = 1'b1;
                        ram_waddr           = pidx_reg;
                        ram_wdata.prior_rem = ram_rdata.rem;
                        ram_wdata.rem       = new_rem;
                        ram_wdata.period    = ram_rdata.period;
                    end
                    if (still_armed && (!min_found_reg || new_rem < min_reg))
                    begin
                        min_found_next = 1'b1;
                        min_next       = new_rem;
                    end
                end
                if (pass_last)
                begin
                    cnt_next        = '0;
                    pv_next         = 1'b0;
                    best_found_next = 1'b0;
                    if (is_tick && (exp_mask_next != '0))
                    begin
                        state_next = ST_SELECT;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SELECT:
            begin
                pv_next = rd_issue;
                if (rd_issue)
                begin
                    ram_re    = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pv_reg && exp_mask_reg[pidx_reg] &&
                    (!best_found_reg || ram_rdata.prior_rem < best_rem_reg))
                begin
                    best_found_next = 1'b1;
                    best_rem_next   = ram_rdata.prior_rem;
                    best_idx_next   = pidx_reg;
                end
                if (pass_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_exp_next    = 1'b1;
                    rsp_id_next     = best_ext[dtl_pkg::ID_W-1:0];
                    rsp_time_next   = next_time;
                    rsp_status_next = 1'b0;
                    rsp_last_next   = (mask_after == '0);
                    exp_mask_next   = mask_after;
                    cnt_next        = '0;
                    pv_next         = 1'b0;
                    best_found_next = 1'b0;
                    if (mask_after == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SELECT;
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_exp_next    = 1'b0;
                    rsp_id_next     = '0;
                    rsp_time_next   = next_time;
                    rsp_status_next = status_reg;
                    rsp_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= '0;
            id_reg         <= '0;
            period_reg     <= '0;
            reload_reg     <= 1'b0;
            elapsed_reg    <= '0;
            status_reg     <= 1'b0;
            armed_reg      <= '0;
            periodic_reg   <= '0;
            exp_mask_reg   <= '0;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
            pidx_reg       <= '0;
            min_found_reg  <= 1'b0;
            min_reg        <= '0;
            best_found_reg <= 1'b0;
            best_rem_reg   <= '0;
            best_idx_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_exp_reg    <= 1'b0;
            rsp_id_reg     <= '0;
            rsp_time_reg   <= '0;
            rsp_status_reg <= 1'b0;
            rsp_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            period_reg     <= period_next;
            reload_reg     <= reload_next;
            elapsed_reg    <= elapsed_next;
            status_reg     <= status_next;
            armed_reg      <= armed_next;
            periodic_reg   <= periodic_next;
            exp_mask_reg   <= exp_mask_next;
            cnt_reg        <= cnt_next;
            pv_reg         <= pv_next;
            pidx_reg       <= pidx_next;
            min_found_reg  <= min_found_next;
            min_reg        <= min_next;
            best_found_reg <= best_found_next;
            best_rem_reg   <= best_rem_next;
            best_idx_reg   <= best_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_exp_reg    <= rsp_exp_next;
            rsp_id_reg     <= rsp_id_next;
            rsp_time_reg   <= rsp_time_next;
            rsp_status_reg <= rsp_status_next;
            rsp_last_reg   <= rsp_last_next;
        end
    end

    // A pending expiry must never be left behind when the sequencer goes idle.
    `DTL_ASSERT_IMP(a_idle_no_pending, state_reg == ST_IDLE, exp_mask_reg == '0, "expiry lost")
    `DTL_ASSERT_IMP(a_pick_has_winner, state_reg == ST_PICK, best_found_reg && exp_mask_reg[best_idx_reg], "no winner in pick")
    `DTL_ASSERT_IMP(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr, "same-slot read and write")
    `DTL_ASSERT_IMP(a_expired_id_range, rsp.valid && rsp.expired_valid, (32'(rsp.expired_id) < 32'(NUM_TIMERS)) && !rsp.status, "bad expiry beat")

endmodule

FILE: tb/dtl_expiry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table response checker
// Watches the command and response channels of the delta timer list manager.
// Every accepted command beat is run through a local copy of the timer table,
// which yields the response beats that the command must produce. Every
// accepted response beat is compared field by field with the oldest of
// them. The number of mismatches and of outstanding beats go to the top.
// ----------------------------------------------------------------------------
module dtl_expiry_checker #(
    parameter int NUM_TIMERS = dtl_pkg::NUM_TIMERS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dtl_cmd_if        cmd,
    dtl_rsp_if        rsp,
    output int        mismatch_count,
    output int        outstanding
);

    import dtl_pkg::*;

    typedef struct packed {
        logic              expired_valid;
        logic [ID_W-1:0]   expired_id;
        logic [TIME_W-1:0] next_timeout_ms;
        logic              status;
        logic              last;
    } expiry_beat_t;

    logic [TIME_W-1:0] time_left     [NUM_TIMERS];
    logic [TIME_W-1:0] reload_period [NUM_TIMERS];
    logic              is_periodic   [NUM_TIMERS];
    logic              is_armed      [NUM_TIMERS];

    expiry_beat_t expected_beats[$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [TIME_W-1:0] soonest_deadline();
        logic [TIME_W-1:0] best;
        bit                found;
        best  = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (is_armed[i] && (!found || time_left[i] < best))
            begin
                best  = time_left[i];
                found = 1'b1;
            end
        end
        return best;
    endfunction

    task automatic predict_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                   input logic [TIME_W-1:0] period, input logic reload,
                                   input logic [TIME_W-1:0] elapsed);
        logic [TIME_W-1:0] snap [NUM_TIMERS];
        bit                due  [NUM_TIMERS];
        int                fired[$];
        int                pick;
        logic              status_bit;
        logic [TIME_W-1:0] soonest;
        status_bit = 1'b0;
        case (op)
            OP_ADD:
            begin
                if (id < NUM_TIMERS)
                begin
                    time_left[id]     = period;
                    reload_period[id] = period;
                    is_periodic[id]   = reload;
                    is_armed[id]      = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (id < NUM_TIMERS && is_armed[id])
                begin
                    is_armed[id]  = 1'b0;
                    time_left[id] = '0;
                end
                else
                begin
                    status_bit = 1'b1;
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    snap[i] = time_left[i];
                    due[i]  = is_armed[i] && time_left[i] <= elapsed;
                end
                do
                begin
                    pick = -1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (due[i] && (pick < 0 || snap[i] < snap[pick]))
                            pick = i;
                    end
                    if (pick >= 0)
                    begin
                        due[pick] = 1'b0;
                        fired.push_back(pick);
                    end
                end
                while (pick >= 0);
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (is_armed[i])
                    begin
                        if (snap[i] <= elapsed)
                        begin
                            if (is_periodic[i])
                            begin
                                time_left[i] = reload_period[i];
                            end
                            else
                            begin
                                is_armed[i]  = 1'b0;
                                time_left[i] = '0;
                            end
                        end
                        else
                        begin
                            time_left[i] = snap[i] - elapsed;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        soonest = soonest_deadline();
        if (fired.size() > 0)
        begin
            for (int k = 0; k < fired.size(); k++)
                expected_beats.push_back('{1'b1, ID_W'(fired[k]), soonest, 1'b0,
                                           k == fired.size() - 1});
        end
        else
        begin
            expected_beats.push_back('{1'b0, '0, soonest, status_bit, 1'b1});
        end
    endtask

    task automatic check_response();
        expiry_beat_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch("response beat arrived with nothing expected");
        end
        else
        begin
            want = expected_beats.pop_front();
            if (rsp.expired_valid !== want.expired_valid)
                report_mismatch($sformatf("expired_valid got %0b expected %0b",
                                          rsp.expired_valid, want.expired_valid));
            if (rsp.expired_id !== want.expired_id)
                report_mismatch($sformatf("expired_id got %0d expected %0d",
                                          rsp.expired_id, want.expired_id));
            if (rsp.next_timeout_ms !== want.next_timeout_ms)
                report_mismatch($sformatf("next_timeout_ms got %0d expected %0d",
                                          rsp.next_timeout_ms, want.next_timeout_ms));
            if (rsp.status !== want.status)
                report_mismatch($sformatf("status got %0b expected %0b",
                                          rsp.status, want.status));
            if (rsp.last !== want.last)
                report_mismatch($sformatf("last got %0b expected %0b",
                                          rsp.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                time_left[i]     = '0;
                reload_period[i] = '0;
                is_periodic[i]   = 1'b0;
                is_armed[i]      = 1'b0;
            end
            expected_beats.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_response();
            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
                predict_command(cmd.operation, cmd.timer_id, cmd.period_ms,
                                cmd.reload_flag, cmd.elapsed_ms);
            outstanding <= expected_beats.size();
        end
    end

endmodule

FILE: tb/tb_delta_timer_list_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta timer list manager testbench
// Drives add, remove, tick and unused commands into the timer table: a
// directed opening for the corner cases, then random traffic in three idle
// phases, with full-table bursts that make sixteen timers expire at once.
// A separate checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb_delta_timer_list_manager_top;

    import dtl_pkg::*;

    localparam int              NUM_TIMERS = NUM_TIMERS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam int              PHASE_ITEMS = 33;

    logic        clk;
    logic        rst_n;
    int          mismatch_count;
    int          outstanding;
    int unsigned cmd_idle_pct;
    int unsigned rsp_idle_pct;
    int          items_sent;

    dtl_cmd_if cmd_ch ();
    dtl_rsp_if rsp_ch ();

    delta_timer_list_manager_top #(
        .NUM_TIMERS (NUM_TIMERS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    dtl_expiry_checker #(
        .NUM_TIMERS (NUM_TIMERS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [TIME_W-1:0] random_duration(input int unsigned short_max);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return TIME_W'($urandom_range(0, short_max));
        else if (r < 85)
            return TIME_W'($urandom());
        else if (r < 92)
            return '1;
        else
            return '0;
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] period, input logic reload,
                            input logic [TIME_W-1:0] elapsed);
        while ($urandom_range(0, 99) < cmd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= op;
        cmd_ch.timer_id    <= id;
        cmd_ch.period_ms   <= period;
        cmd_ch.reload_flag <= reload;
        cmd_ch.elapsed_ms  <= elapsed;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic arm_all_and_tick();
        logic [TIME_W-1:0] period;
        period = TIME_W'($urandom_range(0, 50));
        for (int i = 0; i < NUM_TIMERS; i++)
            send_cmd(OP_ADD, ID_W'(i), period, 1'($urandom()), TIME_W'($urandom()));
        send_cmd(OP_TICK, ID_W'($urandom()), TIME_W'($urandom()), 1'($urandom()),
                 period + TIME_W'($urandom_range(0, 3)));
    endtask

    task automatic random_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_cmd(OP_ADD, ID_W'($urandom()), random_duration(120), 1'($urandom()),
                     TIME_W'($urandom()));
        else if (r < 55)
            send_cmd(OP_REMOVE, ID_W'($urandom()), TIME_W'($urandom()), 1'($urandom()),
                     TIME_W'($urandom()));
        else if (r < 95)
            send_cmd(OP_TICK, ID_W'($urandom()), TIME_W'($urandom()), 1'($urandom()),
                     random_duration(100));
        else
            send_cmd(OP_UNUSED, ID_W'($urandom()), TIME_W'($urandom()), 1'($urandom()),
                     TIME_W'($urandom()));
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.operation   <= OP_ADD;
        cmd_ch.timer_id    <= '0;
        cmd_ch.period_ms   <= '0;
        cmd_ch.reload_flag <= 1'b0;
        cmd_ch.elapsed_ms  <= '0;
        cmd_idle_pct        = 8;
        rsp_idle_pct        = 70;
        items_sent          = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(OP_TICK,   4'd0,  '0, 1'b0, '0);
        send_cmd(OP_REMOVE, 4'd5,  '0, 1'b0, '0);
        send_cmd(OP_UNUSED, 4'd15, '1, 1'b1, '1);
        send_cmd(OP_ADD,    4'd0,  '0, 1'b0, '0);
        send_cmd(OP_ADD,    4'd15, '1, 1'b1, '0);
        send_cmd(OP_ADD,    4'd3,  '0, 1'b1, '0);
        send_cmd(OP_TICK,   4'd0,  '0, 1'b0, '0);
        send_cmd(OP_ADD,    4'd7,  24'd100, 1'b1, '0);
        send_cmd(OP_ADD,    4'd2,  24'd100, 1'b0, '0);
        send_cmd(OP_ADD,    4'd9,  24'd50,  1'b0, '0);
        send_cmd(OP_ADD,    4'd7,  24'd60,  1'b0, '0);
        send_cmd(OP_TICK,   4'd0,  '0, 1'b0, 24'd60);
        send_cmd(OP_REMOVE, 4'd15, '0, 1'b0, '0);
        send_cmd(OP_REMOVE, 4'd15, '0, 1'b0, '0);
        send_cmd(OP_ADD,    4'd1,  '1, 1'b0, '0);
        send_cmd(OP_TICK,   4'd0,  '0, 1'b0, 24'hFFFFFE);
        send_cmd(OP_TICK,   4'd0,  '0, 1'b0, 24'd1);
        send_cmd(OP_ADD,    4'd4,  24'd10, 1'b1, '0);
        send_cmd(OP_ADD,    4'd8,  24'd10, 1'b0, '0);
        send_cmd(OP_TICK,   4'd0,  '0, 1'b0, '1);
        send_cmd(OP_TICK,   4'd0,  '0, 1'b0, '1);
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    cmd_idle_pct = 8;
                    rsp_idle_pct = 70;
                end
                1:
                begin
                    cmd_idle_pct = 70;
                    rsp_idle_pct = 8;
                end
                default:
                begin
                    cmd_idle_pct = 0;
                    rsp_idle_pct = 0;
                end
            endcase
            items_sent = 0;
            arm_all_and_tick();
            while (items_sent < PHASE_ITEMS)
                random_cmd();
            wait_for_drain();
        end

        repeat (4 * NUM_TIMERS) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/dtl_pkg.sv
hdl/dtl_cmd_if.sv
hdl/dtl_rsp_if.sv
hdl/dtl_ram.sv
hdl/delta_timer_list_manager_top.sv
tb/dtl_expiry_checker.sv
tb/tb_delta_timer_list_manager_top.sv
